// ===== rtl/drq_pkg.sv =====
package drq_pkg;

  localparam int FracBits = 48;

  // log10(2) and log2(10) with 48 fraction bits
  localparam logic signed [63:0] L10Q = 64'sd84732411113309;
  localparam logic signed [63:0] L2Q  = 64'sd935039633174599;

  typedef struct packed {
    logic [63:0]        raw;
    logic [52:0]        sig;
    logic signed [11:0] z;
    logic               neg;
    logic               special;
    logic               dbl;
    logic               last;
  } drq_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drq_fifo_stat_t;

  typedef enum logic [0:0] {
    RegDigits = 1'b0,
    RegFormat = 1'b1
  } drq_reg_e;

  // mantissa thresholds, aligned to a 53-bit normalized mantissa
  function automatic logic [52:0] thresh(input logic [1:0] idx);
    logic [52:0] v;
    unique case (idx)
      2'd0: v = 53'd10066330 << 29;
      2'd1: v = 53'd11744051 << 29;
      2'd2: v = 53'd13421773 << 29;
      default: v = 53'd15099494 << 29;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] log_q(input logic [2:0] idx);
    logic signed [63:0] v;
    unique case (idx)
      3'd0: v = -(64'sd10100891 * 64'sd8388608);
      3'd1: v = -(64'sd14888018 * 64'sd4194304);
      3'd2: v = -(64'sd10395294 * 64'sd4194304);
      3'd3: v = -(64'sd13007042 * 64'sd2097152);
      default: v = -(64'sd12282933 * 64'sd1048576);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/drq_front.sv =====
module drq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                dbl_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [63:0]         value_bits_i,
  input  logic                is_last_i,
  input  drq_pkg::drq_fifo_stat_t stat_i,
  output logic                push_o,
  output drq_pkg::drq_item_t  item_o
);

  drq_pkg::drq_item_t item_q, item_d;
  logic               vld_q, vld_d;
  logic               accept;
  logic [63:0]        raw;
  logic [10:0]        ef64;
  logic [7:0]         ef32;

  assign in_stall_o = vld_q & stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = vld_q & ~stat_i.full;
  assign item_o     = item_q;
  assign vld_d      = accept | (vld_q & stat_i.full);

  always_comb begin
    raw  = dbl_i ? value_bits_i : {32'd0, value_bits_i[31:0]};
    ef64 = raw[62:52];
    ef32 = raw[30:23];
    item_d.raw  = raw;
    item_d.dbl  = dbl_i;
    item_d.last = is_last_i;
    if (dbl_i) begin
      item_d.neg     = raw[63];
      item_d.special = (ef64 == 11'h7FF);
      item_d.sig     = {(ef64 != 11'd0), raw[51:0]};
      item_d.z       = (ef64 != 11'd0) ? ($signed({1'b0, ef64}) - 12'sd1075) : -12'sd1074;
    end else begin
      item_d.neg     = raw[31];
      item_d.special = (ef32 == 8'hFF);
      item_d.sig     = {29'd0, (ef32 != 8'd0), raw[22:0]};
      item_d.z       = (ef32 != 8'd0) ? ($signed({4'd0, ef32}) - 12'sd150) : -12'sd149;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/drq_fifo.sv =====
module drq_fifo #(
  parameter int Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  drq_pkg::drq_item_t      item_i,
  input  logic                    pop_i,
  output drq_pkg::drq_item_t      item_o,
  output drq_pkg::drq_fifo_stat_t stat_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  drq_pkg::drq_item_t mem_q [Depth];
  logic [IdxW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] v);
    return (v == IdxW'(Depth - 1)) ? '0 : v + IdxW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? nxt(wr_q) : wr_q;
    rd_d  = pop_i ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty)) else $error("pop from empty queue");

endmodule

// ===== rtl/drq_back.sv =====
module drq_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [3:0]              digits_i,
  input  drq_pkg::drq_item_t      item_i,
  input  drq_pkg::drq_fifo_stat_t stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [63:0]             rounded_bits_o,
  output logic                    last_out_o
);

  typedef struct packed {
    logic [63:0] raw;
    logic        neg;
    logic        special;
    logic        dbl;
    logic        last;
  } meta_t;

  typedef struct packed {
    meta_t              md;
    logic [52:0]        m;
    logic signed [11:0] e;
  } s1_t;

  typedef struct packed {
    meta_t              md;
    logic [52:0]        m;
    logic signed [11:0] e;
    logic signed [63:0] acc;
  } s23_t;

  typedef struct packed {
    meta_t              md;
    logic [63:0]        n;
    logic [6:0]         bln;
    logic signed [13:0] x;
  } s4_t;

  typedef struct packed {
    meta_t              md;
    logic [53:0]        r;
    logic signed [13:0] lsb;
  } s5_t;

  logic [5:1]  vld_q;
  logic        out_vld_q;
  logic        out_dbl_q;
  logic [63:0] out_bits_q, out_bits_d;
  logic        out_last_q;
  logic        adv;

  s1_t  s1_q, s1_d;
  s23_t s2_q, s2_d, s3_q, s3_d;
  s4_t  s4_q, s4_d;
  s5_t  s5_q, s5_d;

  assign adv            = ~out_vld_q | ~out_stall_i;
  assign pop_o          = adv & ~stat_i.empty;
  assign out_valid_o    = out_vld_q;
  assign rounded_bits_o = out_bits_q;
  assign last_out_o     = out_last_q;

  // normalize
  logic [5:0] bl;
  always_comb begin
    bl = 6'd0;
    for (int b = 0; b < 53; b++) begin
      if (item_i.sig[b]) begin
        bl = 6'(b + 1);
      end
    end
    s1_d.md.raw     = item_i.raw;
    s1_d.md.special = item_i.special;
    s1_d.md.dbl     = item_i.dbl;
    s1_d.md.last    = item_i.last;
    if (bl == 6'd0) begin
      s1_d.m      = '0;
      s1_d.e      = '0;
      s1_d.md.neg = 1'b0;
    end else begin
      s1_d.m      = item_i.sig << (6'd53 - bl);
      s1_d.e      = item_i.z + $signed({6'd0, bl});
      s1_d.md.neg = item_i.neg;
    end
  end

  // decimal exponent estimate
  logic [2:0] row;
  always_comb begin
    priority if (s1_q.m <= drq_pkg::thresh(2'd0)) begin
      row = 3'd0;
    end else if (s1_q.m <= drq_pkg::thresh(2'd1)) begin
      row = 3'd1;
    end else if (s1_q.m <= drq_pkg::thresh(2'd2)) begin
      row = 3'd2;
    end else if (s1_q.m <= drq_pkg::thresh(2'd3)) begin
      row = 3'd3;
    end else begin
      row = 3'd4;
    end
    s2_d.md  = s1_q.md;
    s2_d.m   = s1_q.m;
    s2_d.e   = s1_q.e;
    s2_d.acc = 64'(s1_q.e) * drq_pkg::L10Q + drq_pkg::log_q(row);
  end

  // quantum exponent
  logic signed [11:0] dcnt, ddiff;
  always_comb begin
    dcnt     = 12'(s2_q.acc >>> drq_pkg::FracBits) + 12'sd1;
    ddiff    = dcnt - $signed({8'd0, digits_i});
    s3_d.md  = s2_q.md;
    s3_d.m   = s2_q.m;
    s3_d.e   = s2_q.e;
    s3_d.acc = 64'(ddiff) * drq_pkg::L2Q;
  end

  // truncate to the quantum and add half of it
  logic signed [13:0] p, s, ns;
  logic [3:0]         sl;
  logic [63:0]        k;
  logic [6:0]         blk;
  always_comb begin
    p   = 14'(s3_q.acc >>> drq_pkg::FracBits);
    s   = 14'(s3_q.e) - 14'sd53 - p;
    ns  = -s;
    sl  = (s > 14'sd10) ? 4'd10 : s[3:0];
    k   = '0;
    blk = '0;
    if (s >= 14'sd0) begin
      k   = {11'd0, s3_q.m} << sl;
      blk = 7'd53 + {3'd0, sl};
    end else if (ns < 14'sd64) begin
      k   = {11'd0, s3_q.m} >> ns[5:0];
      blk = (ns >= 14'sd53) ? 7'd0 : 7'd53 - {1'b0, ns[5:0]};
    end
    if (s3_q.m == '0) begin
      blk = '0;
    end
    s4_d.md  = s3_q.md;
    s4_d.n   = {k[62:0], 1'b1};
    s4_d.bln = blk + 7'd1;
    s4_d.x   = p - 14'sd1;
  end

  // round to the format's precision
  logic signed [13:0] prec, lo, lsb, sh, nsh;
  logic [63:0]        rr, rem, half, mask;
  logic [5:0]         sh6;
  always_comb begin
    prec = s4_q.md.dbl ? 14'sd53 : 14'sd24;
    lo   = s4_q.md.dbl ? -14'sd1074 : -14'sd149;
    lsb  = s4_q.x + $signed({7'd0, s4_q.bln}) - prec;
    if (lsb < lo) begin
      lsb = lo;
    end
    sh   = lsb - s4_q.x;
    nsh  = -sh;
    sh6  = sh[5:0];
    mask = (64'd1 << sh6) - 64'd1;
    rem  = s4_q.n & mask;
    half = 64'd1 << (sh6 - 6'd1);
    rr   = '0;
    if (sh <= 14'sd0) begin
      rr = s4_q.n << nsh[5:0];
    end else if (sh < 14'sd64) begin
      rr = s4_q.n >> sh6;
      if (rem > half || (rem == half && rr[0])) begin
        rr = rr + 64'd1;
      end
    end
    s5_d.md  = s4_q.md;
    s5_d.r   = rr[53:0];
    s5_d.lsb = lsb;
  end

  // pack
  logic               cy;
  logic [53:0]        r2;
  logic signed [13:0] ex;
  always_comb begin
    cy = s5_q.md.dbl ? s5_q.r[53] : s5_q.r[24];
    r2 = cy ? (s5_q.r >> 1) : s5_q.r;
    ex = s5_q.lsb + $signed({13'd0, cy}) + (s5_q.md.dbl ? 14'sd52 : 14'sd23);
    if (s5_q.md.special) begin
      out_bits_d = s5_q.md.raw;
    end else if (s5_q.md.dbl) begin
      if (!r2[52]) begin
        out_bits_d = {s5_q.md.neg, 11'd0, r2[51:0]};
      end else if (ex > 14'sd1023) begin
        out_bits_d = {s5_q.md.neg, 11'h7FF, 52'd0};
      end else begin
        out_bits_d = {s5_q.md.neg, 11'(ex + 14'sd1023), r2[51:0]};
      end
    end else begin
      if (!r2[23]) begin
        out_bits_d = {32'd0, s5_q.md.neg, 8'd0, r2[22:0]};
      end else if (ex > 14'sd127) begin
        out_bits_d = {32'd0, s5_q.md.neg, 8'hFF, 23'd0};
      end else begin
        out_bits_d = {32'd0, s5_q.md.neg, 8'(ex + 14'sd127), r2[22:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[4:1], pop_o};
      out_vld_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= s1_d;
      s2_q       <= s2_d;
      s3_q       <= s3_d;
      s4_q       <= s4_d;
      s5_q       <= s5_d;
      out_bits_q <= out_bits_d;
      out_last_q <= s5_q.md.last;
      out_dbl_q  <= s5_q.md.dbl;
    end
  end

  a_pass_special: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[5] && s5_q.md.special) |=> (out_bits_q == $past(s5_q.md.raw)))
    else $error("nan or infinity word altered");
  a_single_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_dbl_q) |-> (out_bits_q[63:32] == 32'd0))
    else $error("single word with high bits set");
  a_norm_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !s1_q.md.special && (s1_q.m != '0)) |-> s1_q.m[52])
    else $error("mantissa not normalized");

endmodule

// ===== rtl/digit_rounding_quantizer.sv =====
// Digit-rounding quantizer: each word is one IEEE sample (binary32 in the low
// 32 bits or binary64, chosen by value_format) that comes back with its
// mantissa cut to significant_digits decimal digits plus half a quantum, in
// the same format; NaN and infinity pass unchanged. One word is taken per
// clock while in_stall_o is low, and a word passes from input to output
// through the input register, the queue and the registered arithmetic
// pipeline, whose two constant multiplies sit in separate stages. Write the registers only
// while no word is in flight.
module digit_rounding_quantizer #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] rounded_bits_o,
  output logic        last_out_o
);

  logic [3:0]                 digits_q;
  logic                       fmt_q;
  logic                       wr_en;
  drq_pkg::drq_reg_e          reg_sel;
  drq_pkg::drq_fifo_stat_t    stat;
  drq_pkg::drq_item_t         f_item, b_item;
  logic                       push, pop;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = drq_pkg::drq_reg_e'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      drq_pkg::RegDigits: prdata = {28'd0, digits_q};
      drq_pkg::RegFormat: prdata = {31'd0, fmt_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= 4'd3;
      fmt_q    <= 1'b0;
    end else if (wr_en) begin
      if (reg_sel == drq_pkg::RegDigits) begin
        digits_q <= pwdata[3:0];
      end else begin
        fmt_q <= pwdata[0];
      end
    end
  end

  drq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dbl_i        (fmt_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_bits_i (value_bits_i),
    .is_last_i    (is_last_i),
    .stat_i       (stat),
    .push_o       (push),
    .item_o       (f_item)
  );

  drq_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (b_item),
    .stat_o (stat)
  );

  drq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .digits_i       (digits_q),
    .item_i         (b_item),
    .stat_i         (stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .rounded_bits_o (rounded_bits_o),
    .last_out_o     (last_out_o)
  );

endmodule
